FILE: rtl/sha256_byte_stream_hash_unit_defines.svh
// Assertion macros shared by the SHA-256 stream hash RTL.
// No dependencies; included by files that carry assertions.
`ifndef SHA256_BYTE_STREAM_HASH_UNIT_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASH_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define SHA_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error("%m: lbl");
`define SHA_ASSERT_NR(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) (prop)) else $error("%m: lbl");
`else
`define SHA_ASSERT(lbl, clk_s, rst_s, prop)
`define SHA_ASSERT_NR(lbl, clk_s, prop)
`endif
`endif

FILE: rtl/sha_pkg.sv
// Types, constants and round functions for the SHA-256 stream hash.
// No dependencies.
package sha_pkg;

  localparam logic [1:0] KIND_ABSORB     = 2'd0;
  localparam logic [1:0] KIND_ABSORB_FIN = 2'd1;
  localparam logic [1:0] KIND_FINISH     = 2'd2;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } req_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } req_out_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] h;
    case (i)
      3'd0: h = 32'h6a09e667;
      3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372;
      3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f;
      3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

endpackage

FILE: rtl/sha_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sha_ram #(
  parameter int Width = 32,
  parameter int Depth = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/sha256_byte_stream_hash_unit.sv
// SHA-256 over a byte stream: one byte per cycle while idle into a 512-bit block line,
// 64 rounds per block, chaining words held in an 8x32 RAM (read-modify-write after
// each block). The 64th byte of a block starts a compression: RAM load, rounds and
// RAM update. A finish pads byte by byte (with one or two compressions), then gives
// 8 digest words, each held until out_ready.
// Reset: synchronous; chaining words read as the initial hash until first written.
// Depends on sha_pkg, sha_ram and sha256_byte_stream_hash_unit_defines.svh.
`include "sha256_byte_stream_hash_unit_defines.svh"
module sha256_byte_stream_hash_unit import sha_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  req_in_t  in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output req_out_t out_req
);
  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ROUND, ST_UPD, ST_PAD, ST_OUT
  } state_t;

  state_t        state;
  logic [511:0]  blk;
  logic [6:0]    cnt;
  logic [63:0]   total;
  logic [63:0]   lensh;
  logic [31:0]   v [8];
  logic [5:0]    rnd;
  logic [3:0]    ci;
  logic          ph;
  logic          fresh;
  logic          fin;
  logic          sent80;
  logic          len_ok;
  logic          len_done;
  logic [2:0]    rd_idx_q;

  logic          we;
  logic [31:0]   wdata;
  logic [31:0]   ram_q;
  logic [31:0]   chain_rd;
  logic [7:0]    pad_b;
  logic          pad_is_len;
  logic [31:0]   t1, t2, wnew, s0w, s1w;

  sha_ram #(.Width(32), .Depth(8)) u_chain (
    .clk  (clk),
    .we   (we),
    .waddr(rd_idx_q),
    .wdata(wdata),
    .raddr(ci[2:0]),
    .rdata(ram_q)
  );

  assign in_ready = (state == ST_IDLE);
  assign chain_rd = fresh ? init_hash(rd_idx_q) : ram_q;
  assign we       = (state == ST_UPD) && (ci != 4'd0);
  assign wdata    = chain_rd + v[0];

  always_comb begin
    s0w  = rotr(blk[479:448], 5'd7) ^ rotr(blk[479:448], 5'd18) ^ (blk[479:448] >> 3);
    s1w  = rotr(blk[63:32], 5'd17) ^ rotr(blk[63:32], 5'd19) ^ (blk[63:32] >> 10);
    wnew = s1w + blk[223:192] + s0w + blk[511:480];
    t1   = v[7] + (rotr(v[4], 5'd6) ^ rotr(v[4], 5'd11) ^ rotr(v[4], 5'd25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(rnd) + blk[511:480];
    t2   = (rotr(v[0], 5'd2) ^ rotr(v[0], 5'd13) ^ rotr(v[0], 5'd22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  // Padding byte source: 0x80, then zeros, then the length from position 56 on.
  always_comb begin
    pad_is_len = sent80 && len_ok && (cnt >= 7'd56);
    if (!sent80) begin
      pad_b = PAD_BYTE;
    end else if (pad_is_len) begin
      pad_b = lensh[63:56];
    end else begin
      pad_b = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_q <= ci[2:0];
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      total     <= '0;
      fresh     <= 1'b1;
      fin       <= 1'b0;
      sent80    <= 1'b0;
      len_ok    <= 1'b0;
      len_done  <= 1'b0;
      out_valid <= 1'b0;
      ci        <= '0;
      ph        <= 1'b0;
      rnd       <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          ci <= '0;
          if (in_valid) begin
            case (in_req.kind)
              KIND_ABSORB, KIND_ABSORB_FIN: begin
                blk   <= {blk[503:0], in_req.data_byte};
                cnt   <= cnt + 7'd1;
                total <= total + 64'd8;
                lensh <= total + 64'd8;
                fin   <= (in_req.kind == KIND_ABSORB_FIN);
                if (cnt == 7'd63) begin
                  state <= ST_LOAD;
                end else if (in_req.kind == KIND_ABSORB_FIN) begin
                  state <= ST_PAD;
                end
              end
              KIND_FINISH: begin
                lensh <= total;
                fin   <= 1'b1;
                state <= ST_PAD;
              end
              default: ;
            endcase
          end
        end
        ST_PAD: begin
          blk <= {blk[503:0], pad_b};
          cnt <= cnt + 7'd1;
          if (!sent80) begin
            sent80 <= 1'b1;
            if (cnt < 7'd56) begin
              len_ok <= 1'b1;
            end
          end
          if (pad_is_len) begin
            lensh <= {lensh[55:0], 8'h00};
            if (cnt == 7'd63) begin
              len_done <= 1'b1;
            end
          end
          if (cnt == 7'd63) begin
            ci    <= '0;
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          ci <= ci + 4'd1;
          if (ci != 4'd0) begin
            v[0] <= v[1];
            v[1] <= v[2];
            v[2] <= v[3];
            v[3] <= v[4];
            v[4] <= v[5];
            v[5] <= v[6];
            v[6] <= v[7];
            v[7] <= chain_rd;
          end
          if (ci == 4'd8) begin
            rnd   <= '0;
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          blk  <= {blk[479:0], wnew};
          v[0] <= t1 + t2;
          v[1] <= v[0];
          v[2] <= v[1];
          v[3] <= v[2];
          v[4] <= v[3] + t1;
          v[5] <= v[4];
          v[6] <= v[5];
          v[7] <= v[6];
          rnd  <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            ci    <= '0;
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          ci <= ci + 4'd1;
          if (ci != 4'd0) begin
            v[0] <= v[1];
            v[1] <= v[2];
            v[2] <= v[3];
            v[3] <= v[4];
            v[4] <= v[5];
            v[5] <= v[6];
            v[6] <= v[7];
          end
          if (ci == 4'd8) begin
            fresh <= 1'b0;
            cnt   <= '0;
            ci    <= '0;
            ph    <= 1'b0;
            if (len_done) begin
              state <= ST_OUT;
            end else if (fin) begin
              len_ok <= 1'b1;
              state  <= ST_PAD;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_OUT: begin
          if (!ph) begin
            ph <= 1'b1;
          end else if (!out_valid) begin
            out_valid           <= 1'b1;
            out_req.digest_word <= chain_rd;
            out_req.word_index  <= rd_idx_q;
            out_req.last_word   <= (rd_idx_q == 3'd7);
          end else if (out_ready) begin
            out_valid <= 1'b0;
            ph        <= 1'b0;
            if (ci == 4'd7) begin
              ci       <= '0;
              fresh    <= 1'b1;
              total    <= '0;
              cnt      <= '0;
              fin      <= 1'b0;
              sent80   <= 1'b0;
              len_ok   <= 1'b0;
              len_done <= 1'b0;
              state    <= ST_IDLE;
            end else begin
              ci <= ci + 4'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SHA_ASSERT(a_no_out_when_ready, clk, rst, in_ready |-> !out_valid)
  `SHA_ASSERT(a_cnt_range, clk, rst, cnt <= 7'd64)
  `SHA_ASSERT(a_last_ends, clk, rst, (out_valid && out_ready && out_req.last_word) |=> in_ready)
  `SHA_ASSERT(a_index_order, clk, rst, (out_valid && out_ready && !out_req.last_word) |=> !out_valid)
endmodule
